// ----- rtl/mlbc_pkg.sv -----
// shared types and constants of the markdown line block classifier
package mlbc_pkg;

  // longest line the digit counter is sized for
  localparam int unsigned MAX_LINE         = 4096;
  localparam int unsigned DEF_PREFIX_BYTES = 8;
  localparam int unsigned DLEN_W           = 13;
  // numbered-list digit count saturates here
  localparam int unsigned DIGIT_CAP        = ((MAX_LINE - 2) > 8189) ? 8189 : (MAX_LINE - 2);

  typedef enum logic [2:0] {
    KIND_REGULAR  = 3'd0,
    KIND_HEADING  = 3'd1,
    KIND_QUOTE    = 3'd2,
    KIND_TODO     = 3'd3,
    KIND_BULLET   = 3'd4,
    KIND_NUMBERED = 3'd5,
    KIND_DIVIDER  = 3'd6,
    KIND_DROPCAP  = 3'd7
  } kind_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

endpackage

// ----- rtl/markdown_line_block_classifier.sv -----
// top level of the markdown line block classifier
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | char_byte_i, char_valid_i, line_end_i
//  out     | output    | out_valid_o / out_stall_i| block_kind_o, delimiter_length_o,
//          |           |                          | task_checked_o, drop_letter_o,
//          |           |                          | is_list_item_o, is_indentable_o
//
// one item per cycle sustained unless in_stall_o holds the input; a line's last item passes the
// input register, then line state update and classify into the result register
// the line state (prefix capture, digit run, bytes after digits) is updated once per item
// reset clears all control state; capture buffers need no clearing, their fill counts guard them
// while a result waits under out_stall_i, plain bytes keep flowing; only a second line end stalls
module markdown_line_block_classifier
  import mlbc_pkg::*;
#(
  parameter int unsigned PREFIX_BYTES = DEF_PREFIX_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_byte_i,
  input  logic              char_valid_i,
  input  logic              line_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        block_kind_o,
  output logic [DLEN_W-1:0] delimiter_length_o,
  output logic              task_checked_o,
  output logic [7:0]        drop_letter_o,
  output logic              is_list_item_o,
  output logic              is_indentable_o
);

  localparam int unsigned CNT_W = $clog2(PREFIX_BYTES + 1);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_cvalid_q;
  logic       s1_end_q;
  logic       in_acc;
  logic       s1_adv;
  logic       out_load;

  // line state
  logic              lead_q, lead_d, tk_lead;
  logic [7:0]        prefix_q [PREFIX_BYTES];
  logic [7:0]        tk_prefix [PREFIX_BYTES];
  logic [CNT_W-1:0]  pcnt_q, pcnt_d, tk_pcnt;
  logic [DLEN_W-1:0] drun_q, drun_d, tk_drun;
  logic              ddone_q, ddone_d, tk_ddone;
  logic [7:0]        adig_q [2];
  logic [7:0]        tk_adig [2];
  logic [1:0]        acnt_q, acnt_d, tk_acnt;

  // result register
  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, cls_kind;
  logic [DLEN_W-1:0] out_len_q, cls_len;
  logic              out_chk_q, cls_chk;
  logic [7:0]        out_letter_q, cls_letter;

  // handshake: the input register moves on unless it holds a line end and the
  // result register is full and stalled
  assign s1_adv     = s1_valid_q && !(s1_end_q && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = s1_adv && s1_end_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q   <= char_byte_i;
      s1_cvalid_q <= char_valid_i;
      s1_end_q    <= line_end_i;
    end
  end

  // take one byte into the line state
  always_comb begin
    logic take;
    tk_lead   = lead_q;
    tk_prefix = prefix_q;
    tk_pcnt   = pcnt_q;
    tk_drun   = drun_q;
    tk_ddone  = ddone_q;
    tk_adig   = adig_q;
    tk_acnt   = acnt_q;
    // leading blanks are dropped before anything is captured
    take = s1_cvalid_q &&
           !(lead_q && ((s1_byte_q == CH_SPACE) || (s1_byte_q inside {[CH_TAB:CH_CR]})));
    if (take) begin
      tk_lead = 1'b0;
      if (pcnt_q < CNT_W'(PREFIX_BYTES)) begin
        for (int i = 0; i < PREFIX_BYTES; i++) begin
          if (pcnt_q == CNT_W'(i)) begin
            tk_prefix[i] = s1_byte_q;
          end
        end
        tk_pcnt = pcnt_q + CNT_W'(1);
      end
      if (!ddone_q) begin
        if (s1_byte_q inside {[CH_ZERO:CH_NINE]}) begin
          if (drun_q < DLEN_W'(DIGIT_CAP)) begin
            tk_drun = drun_q + DLEN_W'(1);
          end
        end else begin
          tk_ddone   = 1'b1;
          tk_adig[0] = s1_byte_q;
          tk_acnt    = 2'd1;
        end
      end else if (acnt_q < 2'd2) begin
        tk_adig[acnt_q[0]] = s1_byte_q;
        tk_acnt            = acnt_q + 2'd1;
      end
    end
  end

  // classify the line from the state that includes the last item; first match wins
  always_comb begin
    logic [7:0] b0, b1, b2, b3, b4, b5;
    logic       hit_head;
    logic [2:0] head_n;
    logic       all_hash;
    b0 = tk_prefix[0];
    b1 = tk_prefix[1];
    b2 = tk_prefix[2];
    b3 = tk_prefix[3];
    b4 = tk_prefix[4];
    b5 = tk_prefix[5];
    hit_head = 1'b0;
    head_n   = 3'd0;
    // heading: one to six hashes then a space; at most one length can match
    for (int h = 1; h <= 6; h++) begin
      all_hash = 1'b1;
      for (int j = 0; j < 6; j++) begin
        if (j < h && tk_prefix[j] != CH_HASH) begin
          all_hash = 1'b0;
        end
      end
      if (all_hash && tk_pcnt > CNT_W'(h) && tk_prefix[h] == CH_SPACE) begin
        hit_head = 1'b1;
        head_n   = 3'(h);
      end
    end

    cls_kind   = KIND_REGULAR;
    cls_len    = '0;
    cls_chk    = 1'b0;
    cls_letter = 8'd0;
    if (hit_head) begin
      cls_kind = KIND_HEADING;
      cls_len  = DLEN_W'(head_n) + DLEN_W'(1);
    end else if (tk_pcnt >= CNT_W'(2) && b0 == CH_PIPE && b1 == CH_SPACE) begin
      cls_kind = KIND_QUOTE;
      cls_len  = DLEN_W'(2);
    end else if (tk_pcnt >= CNT_W'(2) && b0 == CH_GT && b1 == CH_SPACE) begin
      cls_kind = KIND_QUOTE;
      cls_len  = DLEN_W'(2);
    end else if (tk_pcnt >= CNT_W'(3) && b0 == CH_GT && b1 == CH_GT && b2 == CH_SPACE) begin
      cls_kind = KIND_QUOTE;
      cls_len  = DLEN_W'(3);
    end else if (tk_pcnt >= CNT_W'(4) && b0 == CH_GT && b1 == CH_GT && b2 == CH_GT &&
                 b3 == CH_SPACE) begin
      cls_kind = KIND_QUOTE;
      cls_len  = DLEN_W'(4);
    end else if (tk_pcnt >= CNT_W'(4) && b0 == CH_LBRK && (b1 inside {CH_SPACE, CH_LOW_X}) &&
                 b2 == CH_RBRK && b3 == CH_SPACE) begin
      cls_kind = KIND_TODO;
      cls_len  = DLEN_W'(4);
      cls_chk  = (b1 == CH_LOW_X) || (b3 == CH_LOW_X);
    end else if (tk_pcnt >= CNT_W'(6) && (b0 inside {CH_DASH, CH_STAR, CH_PLUS}) &&
                 b1 == CH_SPACE && b2 == CH_LBRK && (b3 inside {CH_SPACE, CH_LOW_X}) &&
                 b4 == CH_RBRK && b5 == CH_SPACE) begin
      cls_kind = KIND_TODO;
      cls_len  = DLEN_W'(6);
      cls_chk  = (b1 == CH_LOW_X) || (b3 == CH_LOW_X);
    end else if (tk_pcnt >= CNT_W'(2) && (b0 inside {CH_DASH, CH_STAR, CH_PLUS}) &&
                 b1 == CH_SPACE) begin
      cls_kind = KIND_BULLET;
      cls_len  = DLEN_W'(2);
    end else if (tk_drun != '0 && tk_acnt == 2'd2 && tk_adig[0] == CH_DOT &&
                 tk_adig[1] == CH_SPACE) begin
      cls_kind = KIND_NUMBERED;
      cls_len  = tk_drun + DLEN_W'(2);
    end else if (tk_pcnt >= CNT_W'(3) && b0 == CH_DASH && b1 == CH_DASH && b2 == CH_DASH) begin
      cls_kind = KIND_DIVIDER;
      cls_len  = DLEN_W'(3);
    end else if (tk_pcnt >= CNT_W'(2) && b0 == CH_CARET) begin
      cls_kind   = KIND_DROPCAP;
      cls_len    = DLEN_W'(2);
      cls_letter = (b1 inside {[CH_LOW_A:CH_LOW_Z]}) ? (b1 - CASE_BIT) : b1;
    end
  end

  // a line end returns the line state to its start
  always_comb begin
    if (s1_end_q) begin
      lead_d  = 1'b1;
      pcnt_d  = '0;
      drun_d  = '0;
      ddone_d = 1'b0;
      acnt_d  = 2'd0;
    end else begin
      lead_d  = tk_lead;
      pcnt_d  = tk_pcnt;
      drun_d  = tk_drun;
      ddone_d = tk_ddone;
      acnt_d  = tk_acnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= 1'b1;
      pcnt_q  <= '0;
      drun_q  <= '0;
      ddone_q <= 1'b0;
      acnt_q  <= 2'd0;
    end else if (s1_adv) begin
      lead_q  <= lead_d;
      pcnt_q  <= pcnt_d;
      drun_q  <= drun_d;
      ddone_q <= ddone_d;
      acnt_q  <= acnt_d;
    end
  end

  // capture buffers are guarded by their fill counts
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      prefix_q <= tk_prefix;
      adig_q   <= tk_adig;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q   <= cls_kind;
      out_len_q    <= cls_len;
      out_chk_q    <= cls_chk;
      out_letter_q <= cls_letter;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign block_kind_o       = out_kind_q;
  assign delimiter_length_o = out_len_q;
  assign task_checked_o     = out_chk_q;
  assign drop_letter_o      = out_letter_q;
  assign is_list_item_o     = (out_kind_q == KIND_TODO) || (out_kind_q == KIND_BULLET) ||
                              (out_kind_q == KIND_NUMBERED);
  assign is_indentable_o    = (out_kind_q != KIND_DROPCAP);

endmodule

// ----- rtl/mlbc_checker.sv -----
// port-level checks of the markdown line block classifier and their binding
module mlbc_checker
  import mlbc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              line_end_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [2:0]        block_kind_o,
  input logic [DLEN_W-1:0] delimiter_length_o,
  input logic              task_checked_o,
  input logic [7:0]        drop_letter_o,
  input logic              is_list_item_o,
  input logic              is_indentable_o
);

  // a stalled result holds its kind and length
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_kind_o) &&
                                   $stable(delimiter_length_o))
    else $error("stalled result changed");

  // regular text carries no delimiter, no letter and no check mark
  a_regular_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_kind_o == KIND_REGULAR |->
      delimiter_length_o == '0 && drop_letter_o == 8'd0 && !task_checked_o)
    else $error("regular item with delimiter fields");

  // flags follow the kind
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (is_indentable_o == (block_kind_o != KIND_DROPCAP)) &&
      (is_list_item_o == (block_kind_o == KIND_TODO || block_kind_o == KIND_BULLET ||
                          block_kind_o == KIND_NUMBERED)))
    else $error("flags disagree with kind");

  // a check mark only appears on a to-do, a letter only on a drop cap
  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!task_checked_o || block_kind_o == KIND_TODO) &&
                    (drop_letter_o == 8'd0 || block_kind_o == KIND_DROPCAP))
    else $error("field set for wrong kind");

  // a new result needs an accepted line end, which passes two stages, the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && line_end_i, 2))
    else $error("result without a line end two cycles earlier");

endmodule

bind markdown_line_block_classifier mlbc_checker u_mlbc_checker (.*);
